[src/lz77td_pkg.sv]
// ----------------------------------------------------------------------------
// lz77td_pkg
// shared types and constants of the lz77 token decompressor
// ----------------------------------------------------------------------------
package lz77td_pkg;

  // default sizes
  localparam int unsigned WINDOW_SIZE_DEF = 4096;
  localparam int unsigned MAX_MATCH_DEF   = 15;

  // fixed field widths
  localparam int unsigned DIST_W = 13;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 32;

  // input word: one lz77 triple
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  match_length;
    logic [BYTE_W-1:0] literal;
  } token_t;

  // output word: one restored byte
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_token;
    logic              malformed;
    logic              finished;
  } result_t;

  // classified token handed from front to back
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  length;
    logic              len_zero;
    logic              dist_bad;
    logic [BYTE_W-1:0] literal;
  } cmd_t;

endpackage

[src/lz77_token_decompressor.sv]
// ----------------------------------------------------------------------------
// lz77_token_decompressor
// lz77 triple decoder with a history window ring
// ----------------------------------------------------------------------------
// A token is fetched and checked, then restored one byte per cycle as long
// as the output register is free or being read; this rate is set by the
// single read port of the history window and the one-word output register.
// A dropped token (stream complete) gives no output word, a malformed one a
// single flagged word. The window needs no clearing after reset.
module lz77_token_decompressor #(
  parameter int unsigned WINDOW_SIZE = lz77td_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lz77td_pkg::MAX_MATCH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lz77td_pkg::SIZE_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lz77td_pkg::token_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lz77td_pkg::result_t           out_data_o
);

  logic             cmd_valid, cmd_ready;
  lz77td_pkg::cmd_t cmd;

  // size register always takes a write
  assign cfg_ready_o = 1'b1;

  // front end: accept and classify
  lz77td_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_MATCH   (MAX_MATCH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back end: copy and emit
  lz77td_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/lz77td_front.sv]
// ----------------------------------------------------------------------------
// lz77td_front
// accepts tokens, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module lz77td_front #(
  parameter int unsigned WINDOW_SIZE = lz77td_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned MAX_MATCH   = lz77td_pkg::MAX_MATCH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lz77td_pkg::token_t  in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output lz77td_pkg::cmd_t    cmd_o
);

  localparam int unsigned DEPTH = 2;

  lz77td_pkg::cmd_t entry_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  lz77td_pkg::cmd_t cls;
  logic             push, pop;

  // classify: saturate length, flag distances that can never be valid
  always_comb begin
    cls.distance = in_data_i.distance;
    cls.literal  = in_data_i.literal;
    if (32'(in_data_i.match_length) > MAX_MATCH) begin
      cls.length = lz77td_pkg::LEN_W'(MAX_MATCH);
    end else begin
      cls.length = in_data_i.match_length;
    end
    cls.len_zero = (cls.length == '0);
    cls.dist_bad = (in_data_i.distance == '0) ||
                   (32'(in_data_i.distance) > WINDOW_SIZE);
  end

  // two-word queue
  assign in_ready_o  = (cnt_q != 2'(DEPTH));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[src/lz77td_back.sv]
// ----------------------------------------------------------------------------
// lz77td_back
// runs classified tokens on the history window: a byte a cycle unless stalled
// ----------------------------------------------------------------------------
module lz77td_back #(
  parameter int unsigned WINDOW_SIZE = lz77td_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [lz77td_pkg::SIZE_W-1:0]          cfg_data_i,
  input  logic                                   cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  lz77td_pkg::cmd_t                       cmd_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output lz77td_pkg::result_t                    out_data_o
);

  localparam int unsigned AW  = $clog2(WINDOW_SIZE);
  localparam int unsigned SW  = lz77td_pkg::SIZE_W;
  localparam int unsigned BW  = lz77td_pkg::BYTE_W;
  localparam int unsigned LW  = lz77td_pkg::LEN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_LIT   = 3'd3;
  localparam logic [2:0] ST_BAD   = 3'd4;

  localparam logic [SW-1:0] CNT_MAX = '1;
  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_SIZE - 1);
  localparam logic [AW:0]   WIN_EXT  = (AW+1)'(WINDOW_SIZE);

  logic [BW-1:0]       mem_q [WINDOW_SIZE];
  logic [BW-1:0]       rdata_q;

  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       size_q;
  logic [SW-1:0]       count_q, count_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [AW-1:0]       rp_q, rp_d;
  logic [lz77td_pkg::DIST_W-1:0] dist_q;
  logic [LW-1:0]       len_q, len_d;
  logic                len_zero_q, dist_bad_q;
  logic [BW-1:0]       lit_q;

  logic                out_valid_q, out_valid_d;
  lz77td_pkg::result_t out_q, out_d;

  logic                can_emit, we, step;
  logic [BW-1:0]       wdata;
  logic [AW:0]         rp_sum;
  logic [AW-1:0]       rp_start;
  logic                done, bad;

  // start of copy: slot distance bytes behind the write pointer
  always_comb begin
    rp_sum = {1'b0, wp_q} + WIN_EXT - (AW+1)'(cmd_i.distance);
    if (rp_sum >= WIN_EXT) begin
      rp_sum = rp_sum - WIN_EXT;
    end
    rp_start = rp_sum[AW-1:0];
  end

  assign can_emit    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign done        = (count_q >= size_q);
  assign bad         = dist_bad_q || (SW'(dist_q) > count_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    we          = 1'b0;
    wdata       = rdata_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_CHECK;
          len_d   = cmd_i.length;
        end
      end
      ST_CHECK: begin
        if (done) begin
          state_d = ST_IDLE;
        end else if (len_zero_q) begin
          state_d = ST_LIT;
        end else if (bad) begin
          state_d = ST_BAD;
        end else begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if (can_emit) begin
          we    = 1'b1;
          wdata = rdata_q;
          len_d = len_q - LW'(1);
        end
      end
      ST_LIT: begin
        if (can_emit) begin
          we      = 1'b1;
          wdata   = lit_q;
          state_d = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (can_emit) begin
          out_valid_d         = 1'b1;
          out_d.data_byte     = '0;
          out_d.last_of_token = 1'b1;
          out_d.malformed     = 1'b1;
          out_d.finished      = done;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // pointer and count advance with every byte produced
    step    = we;
    wp_d    = wp_q;
    rp_d    = (state_q == ST_IDLE) ? rp_start : rp_q;
    count_d = count_q;
    if (step) begin
      wp_d    = (wp_q == PTR_LAST) ? '0 : wp_q + AW'(1);
      rp_d    = (rp_q == PTR_LAST) ? '0 : rp_q + AW'(1);
      count_d = (count_q == CNT_MAX) ? count_q : count_q + SW'(1);
      out_valid_d         = 1'b1;
      out_d.data_byte     = wdata;
      out_d.malformed     = 1'b0;
      out_d.finished      = (count_d >= size_q);
      out_d.last_of_token = (state_q == ST_LIT);
      if (state_q == ST_COPY && len_q == LW'(1)) begin
        // literal follows only while the stream is short of its size
        if (count_d < size_q) begin
          state_d = ST_LIT;
        end else begin
          state_d             = ST_IDLE;
          out_d.last_of_token = 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      count_q     <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rp_q  <= rp_d;
    len_q <= len_d;
    out_q <= out_d;
    if (state_q == ST_IDLE && cmd_valid_i) begin
      dist_q     <= cmd_i.distance;
      len_zero_q <= cmd_i.len_zero;
      dist_bad_q <= cmd_i.dist_bad;
      lit_q      <= cmd_i.literal;
    end
  end

  // history window, read ahead at the next copy slot with write bypass
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wp_q] <= wdata;
    end
    if (we && wp_q == rp_d) begin
      rdata_q <= wdata;
    end else begin
      rdata_q <= mem_q[rp_d];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lz77 token decompressor: a directed table of
// tokens and size writes, then random token streams under three idling
// regimes, each output word compared with a table entry or the behavioral decoder
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_SIZE_DEF = lz77td_pkg::WINDOW_SIZE_DEF;
  localparam int unsigned MAX_MATCH_DEF   = lz77td_pkg::MAX_MATCH_DEF;
  localparam int unsigned DIST_W          = lz77td_pkg::DIST_W;
  localparam int unsigned LEN_W           = lz77td_pkg::LEN_W;
  localparam int unsigned BYTE_W          = lz77td_pkg::BYTE_W;
  localparam int unsigned SIZE_W          = lz77td_pkg::SIZE_W;

  localparam int unsigned PTR_W          = $clog2(WINDOW_SIZE_DEF);
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 24;

  // kinds of directed table rows
  typedef enum logic [0:0] {ROW_TOKEN, ROW_SIZE} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [SIZE_W-1:0]   size;
    lz77td_pkg::token_t  tok;
    bit                  typed;
    int unsigned         n_typed;
    lz77td_pkg::result_t typed_res;
  } row_t;

  // dut ports
  logic                cfg_valid_i = 1'b0;
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_ready_o;
  logic [SIZE_W-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  lz77td_pkg::token_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  lz77td_pkg::result_t out_data_o;

  // decoder copy: history ring, write pointer, byte count, size register
  logic [BYTE_W-1:0] hist_win [WINDOW_SIZE_DEF];
  logic [PTR_W-1:0]  wr_ptr    = '0;
  logic [SIZE_W-1:0] produced  = '0;
  logic [SIZE_W-1:0] orig_size = '0;

  lz77td_pkg::result_t token_bytes[$];
  lz77td_pkg::result_t expected_bytes[$];
  row_t                plan[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors        = 0;
  int unsigned quiet_cycles  = 0;

  lz77_token_decompressor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic lz77td_pkg::result_t mk_res(logic [BYTE_W-1:0] b, logic last,
                                                 logic bad, logic fin);
    lz77td_pkg::result_t r;
    r.data_byte     = b;
    r.last_of_token = last;
    r.malformed     = bad;
    r.finished      = fin;
    return r;
  endfunction

  // append one restored byte to the ring, count saturates
  function automatic void store_byte(logic [BYTE_W-1:0] b);
    hist_win[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (produced != '1) produced = produced + 1'b1;
  endfunction

  // decode one token into token_bytes, updating the ring and the count
  function automatic void restore_token(lz77td_pkg::token_t tok);
    logic [LEN_W-1:0]  len;
    logic [PTR_W-1:0]  idx;
    logic [BYTE_W-1:0] b;
    token_bytes.delete();
    if (produced >= orig_size) return;
    len = (tok.match_length > MAX_MATCH_DEF) ? LEN_W'(MAX_MATCH_DEF)
                                             : tok.match_length;
    if (len != 0) begin
      // distance zero, past the produced bytes or past the window
      if (tok.distance == 0 || tok.distance > produced ||
          tok.distance > WINDOW_SIZE_DEF) begin
        token_bytes.insert(token_bytes.size(),
                           mk_res('0, 1'b1, 1'b1, produced >= orig_size));
        return;
      end
      for (int j = 0; j < int'(len); j++) begin
        idx = wr_ptr - tok.distance[PTR_W-1:0];
        b   = hist_win[idx];
        store_byte(b);
        token_bytes.insert(token_bytes.size(),
                           mk_res(b, 1'b0, 1'b0, produced >= orig_size));
      end
    end
    // literal only while still short of the size
    if (produced < orig_size) begin
      store_byte(tok.literal);
      token_bytes.insert(token_bytes.size(),
                         mk_res(tok.literal, 1'b0, 1'b0, produced >= orig_size));
    end
    if (token_bytes.size() > 0) begin
      token_bytes[token_bytes.size() - 1].last_of_token = 1'b1;
    end
  endfunction

  // mostly copies that reach back into written data, some raw noise
  function automatic lz77td_pkg::token_t random_token();
    lz77td_pkg::token_t t;
    int unsigned        reach;
    reach = (produced > WINDOW_SIZE_DEF) ? WINDOW_SIZE_DEF : int'(produced);
    t.literal = BYTE_W'($urandom_range(255));
    if (reach == 0 || $urandom_range(99) < 25) begin
      t.distance     = DIST_W'($urandom_range(8191));
      t.match_length = LEN_W'($urandom_range(15));
    end else begin
      t.match_length = ($urandom_range(99) < 60) ? LEN_W'(15) : LEN_W'($urandom_range(15));
      if ($urandom_range(9) == 0) t.distance = DIST_W'(reach);
      else t.distance = DIST_W'($urandom_range(reach, 1));
    end
    return t;
  endfunction

  function automatic row_t tok_row(int unsigned d, int unsigned l, int unsigned lit);
    row_t r;
    r.kind      = ROW_TOKEN;
    r.size      = '0;
    r.tok       = {DIST_W'(d), LEN_W'(l), BYTE_W'(lit)};
    r.typed     = 1'b0;
    r.n_typed   = 0;
    r.typed_res = '0;
    return r;
  endfunction

  function automatic row_t typed_row(int unsigned d, int unsigned l, int unsigned lit,
                                     int unsigned n, lz77td_pkg::result_t res);
    row_t r;
    r           = tok_row(d, l, lit);
    r.typed     = 1'b1;
    r.n_typed   = n;
    r.typed_res = res;
    return r;
  endfunction

  function automatic row_t size_row(logic [SIZE_W-1:0] v);
    row_t r;
    r      = tok_row(0, 0, 0);
    r.kind = ROW_SIZE;
    r.size = v;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // present one token word and decode it at the accepting edge
  task automatic send_token(lz77td_pkg::token_t tok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tok;
    do @(posedge clk_i); while (!in_ready_o);
    restore_token(tok);
  endtask

  task automatic send_predicted(lz77td_pkg::token_t tok);
    send_token(tok);
    foreach (token_bytes[k]) expected_bytes.insert(expected_bytes.size(), token_bytes[k]);
  endtask

  // hold input, let every expected word drain, then let the design sit quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    orig_size = v;
  endtask

  // random tokens; when the stream is complete, feed two more then grow the size
  task automatic random_phase(int unsigned n_items, bit hold_midway);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if (produced >= orig_size) begin
        repeat (2) send_predicted(random_token());
        settle();
        write_size(produced + $urandom_range(1500, 40));
      end
      send_predicted(random_token());
      sent++;
      if (hold_midway && sent == n_items / 2) settle();
    end
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output checker
  always @(posedge clk_i) begin
    lz77td_pkg::result_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, out_data_o);
        errors++;
      end else begin
        exp_res = expected_bytes.pop_front();
        if (out_data_o.data_byte !== exp_res.data_byte ||
            out_data_o.last_of_token !== exp_res.last_of_token ||
            out_data_o.malformed !== exp_res.malformed ||
            out_data_o.finished !== exp_res.finished) begin
          $display({"%0t: mismatch expected byte %h last %b bad %b fin %b, ",
                    "got byte %h last %b bad %b fin %b"},
                   $realtime, exp_res.data_byte, exp_res.last_of_token,
                   exp_res.malformed, exp_res.finished, out_data_o.data_byte,
                   out_data_o.last_of_token, out_data_o.malformed,
                   out_data_o.finished);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    // size 0 after reset: stream already complete
    add_row(typed_row(0, 0, 'h3C, 0, '0));
    add_row(typed_row(8191, 15, 'hFF, 0, '0));
    add_row(size_row('1));
    add_row(typed_row(0, 0, 'h00, 1, mk_res(8'h00, 1'b1, 1'b0, 1'b0)));
    // zero distance, distance past produced data
    add_row(typed_row(0, 7, 'h11, 1, mk_res(8'h00, 1'b1, 1'b1, 1'b0)));
    add_row(typed_row(2, 1, 'h22, 1, mk_res(8'h00, 1'b1, 1'b1, 1'b0)));
    // longest overlapping copy
    add_row(tok_row(1, 15, 'hFF));
    // distance past the window, full window distance before it is filled
    add_row(typed_row(8191, 4, 'h33, 1, mk_res(8'h00, 1'b1, 1'b1, 1'b0)));
    add_row(typed_row(4096, 2, 'h44, 1, mk_res(8'h00, 1'b1, 1'b1, 1'b0)));
    // zero length ignores the distance
    add_row(typed_row(5000, 0, 'h80, 1, mk_res(8'h80, 1'b1, 1'b0, 1'b0)));
    add_row(tok_row(18, 15, 'h01));
    add_row(tok_row(3, 8, 'hFE));
    add_row(tok_row(1, 1, 'h7F));
    // copy runs past the size, literal dropped, then stream complete
    add_row(size_row(48));
    add_row(tok_row(5, 10, 'h55));
    add_row(typed_row(1, 0, 'h66, 0, '0));
    // literal lands exactly on the size
    add_row(size_row(60));
    add_row(tok_row(2, 4, 'h99));
    add_row(typed_row(3, 2, 'h77, 0, '0));
    add_row(size_row('1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    send_idle_pct = 27;
    recv_idle_pct = 83;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SIZE) begin
        settle();
        write_size(plan[i].size);
      end else if (plan[i].typed) begin
        send_token(plan[i].tok);
        if (plan[i].n_typed != 0) begin
          expected_bytes.insert(expected_bytes.size(), plan[i].typed_res);
        end
      end else begin
        send_predicted(plan[i].tok);
      end
    end

    // random streams under the three idling regimes
    random_phase(30, 1'b0);

    settle();
    send_idle_pct = 83;
    recv_idle_pct = 27;
    write_size(produced + $urandom_range(400, 30));
    random_phase(30, 1'b1);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(produced + $urandom_range(400, 30));
    random_phase(30, 1'b0);

    // drain and verdict
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
